// ===== rtl/mqwtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqwtm_pkg
// Shared types and codes of the multi-queue wait time monitor.
// ----------------------------------------------------------------------------
package mqwtm_pkg;

  localparam logic [1:0] CMD_ENTER = 2'd0;
  localparam logic [1:0] CMD_EXIT  = 2'd1;

  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;
  localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_ENTER  = 2'd0,
    OP_EXIT   = 2'd1,
    OP_REPORT = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  queue_id;
    logic [10:0] event_time;
  } item_t;

  typedef struct packed {
    logic [3:0]  queue_sel;
    status_t     status;
    logic [10:0] wait_minutes;
    logic [31:0] wait_total;
    logic [23:0] served_total;
    logic [23:0] idle_events;
    logic [6:0]  peak_length;
    logic [6:0]  current_length;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/mqwtm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqwtm_front
// Accepts command transactions, classifies them and holds them in a
// two-entry queue for the update engine.
// ----------------------------------------------------------------------------
module mqwtm_front #(
  parameter int NUM_QUEUES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd,
  input  wire logic [3:0]       queue_id,
  input  wire logic [10:0]      event_time,
  output mqwtm_pkg::item_t      item,
  output logic                  item_valid,
  input  wire logic             pop
);

  mqwtm_pkg::item_t slot [2];
  mqwtm_pkg::item_t in_item;
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  always_comb begin
    in_item.queue_id   = queue_id;
    in_item.event_time = event_time;
    if (int'(queue_id) >= NUM_QUEUES) begin
      in_item.op = mqwtm_pkg::OP_IGNORE;
    end else if (cmd == mqwtm_pkg::CMD_ENTER) begin
      in_item.op = mqwtm_pkg::OP_ENTER;
    end else if (cmd == mqwtm_pkg::CMD_EXIT) begin
      in_item.op = mqwtm_pkg::OP_EXIT;
    end else begin
      in_item.op = mqwtm_pkg::OP_REPORT;
    end
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mqwtm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqwtm_back
// Update engine: per-queue statistics table, arrival timestamp store and
// the sequencer that applies one transaction at a time.
// ----------------------------------------------------------------------------
module mqwtm_back #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mqwtm_pkg::item_t  item,
  input  wire logic              item_valid,
  output logic                   pop,
  output mqwtm_pkg::res_t        res,
  output logic                   done
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam logic [OW-1:0] OCC_FULL  = OW'(QUEUE_DEPTH);
  localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);
  localparam logic [HW:0]   DEPTH_X   = (HW + 1)'(QUEUE_DEPTH);

  typedef struct packed {
    logic [HW-1:0] head;
    logic [OW-1:0] occ;
    logic [31:0]   sum;
    logic [23:0]   served;
    logic [23:0]   idle;
    logic [OW-1:0] peak;
  } qstat_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_FETCH = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  mqwtm_pkg::item_t   cur;
  logic [QW-1:0]      cur_idx;

  qstat_t             stat_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] stat_vld;
  qstat_t             stat_rd;
  logic               stat_rd_vld;
  qstat_t             st;
  qstat_t             st_next;
  logic               stat_we;

  logic [10:0]        arr_mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [10:0]        arr_rd;
  logic [AW-1:0]      arr_addr;
  logic [AW-1:0]      arr_addr_q;
  logic [HW:0]        tail_sum;
  logic [HW-1:0]      tail_pos;
  logic [HW-1:0]      pos;
  logic               arr_we;

  mqwtm_pkg::status_t status;
  logic [10:0]        wait_val;
  logic [32:0]        sum_ext;
  mqwtm_pkg::res_t    res_next;

  assign cur_idx = QW'(cur.queue_id);
  assign st      = stat_rd_vld ? stat_rd : '0;
  assign pop     = (state == S_IDLE) && item_valid;

  always_comb begin
    tail_sum = (HW + 1)'(st.head) + (HW + 1)'(st.occ);
    if (tail_sum >= DEPTH_X) begin
      tail_sum = tail_sum - DEPTH_X;
    end
    tail_pos = tail_sum[HW-1:0];
    pos      = (cur.op == mqwtm_pkg::OP_ENTER) ? tail_pos : st.head;
    arr_addr = AW'(cur_idx) * AW'(QUEUE_DEPTH) + AW'(pos);
  end

  always_comb begin
    st_next  = st;
    status   = mqwtm_pkg::ST_OK;
    wait_val = 11'd0;
    arr_we   = 1'b0;
    sum_ext  = 33'd0;
    case (cur.op)
      mqwtm_pkg::OP_ENTER: begin
        if (st.occ == OCC_FULL) begin
          status = mqwtm_pkg::ST_FULL;
        end else begin
          st_next.occ = st.occ + OW'(1);
          arr_we      = 1'b1;
        end
      end
      mqwtm_pkg::OP_EXIT: begin
        if (st.occ == '0) begin
          status = mqwtm_pkg::ST_EMPTY;
        end else begin
          wait_val = (cur.event_time > arr_rd) ? (cur.event_time - arr_rd) : 11'd0;
          sum_ext  = {1'b0, st.sum} + 33'(wait_val);
          st_next.sum = sum_ext[32] ? mqwtm_pkg::SUM_MAX : sum_ext[31:0];
          if (st.served != mqwtm_pkg::CNT_MAX) begin
            st_next.served = st.served + 24'd1;
          end
          st_next.head = (st.head == HEAD_LAST) ? '0 : st.head + HW'(1);
          st_next.occ  = st.occ - OW'(1);
          if (st.occ == OW'(1) && st.idle != mqwtm_pkg::CNT_MAX) begin
            st_next.idle = st.idle + 24'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (st_next.occ > st_next.peak) begin
      st_next.peak = st_next.occ;
    end
  end

  assign stat_we = (state == S_EXEC) && (cur.op != mqwtm_pkg::OP_IGNORE);

  always_comb begin
    res_next.queue_sel = cur.queue_id;
    if (cur.op == mqwtm_pkg::OP_IGNORE) begin
      res_next.status         = mqwtm_pkg::ST_OK;
      res_next.wait_minutes   = 11'd0;
      res_next.wait_total     = 32'd0;
      res_next.served_total   = 24'd0;
      res_next.idle_events    = 24'd0;
      res_next.peak_length    = 7'd0;
      res_next.current_length = 7'd0;
    end else begin
      res_next.status         = status;
      res_next.wait_minutes   = wait_val;
      res_next.wait_total     = st_next.sum;
      res_next.served_total   = st_next.served;
      res_next.idle_events    = st_next.idle;
      res_next.peak_length    = 7'(st_next.peak);
      res_next.current_length = 7'(st_next.occ);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_valid) state_next = S_LOOK;
      S_LOOK:  state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[cur_idx] <= st_next;
    end
    if (state == S_LOOK) begin
      stat_rd <= stat_mem[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && arr_we) begin
      arr_mem[arr_addr_q] <= cur.event_time;
    end
    if (state == S_FETCH) begin
      arr_rd <= arr_mem[arr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= item;
    end
    if (state == S_LOOK) begin
      stat_rd_vld <= stat_vld[cur_idx];
    end
    if (state == S_FETCH) begin
      arr_addr_q <= arr_addr;
    end
    if (state == S_EXEC) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      stat_vld <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (stat_we) begin
        stat_vld[cur_idx] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/multi_queue_wait_time_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_wait_time_monitor
// Per-queue arrival timestamp FIFOs with wait time and occupancy statistics.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each transaction yields exactly
// one result, shown for one cycle with done high; the receiver cannot stall
// it. The update engine works through each transaction in order: dequeue,
// table lookup, arrival-store read, then update and write-back. It takes
// the next transaction only after the current one is written back. No
// clearing pass follows reset: the statistics table has a valid bit per
// queue.
module multi_queue_wait_time_monitor #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  queue_id,
  input  wire logic [10:0] event_time,
  output logic             done,
  output logic [3:0]       queue_sel,
  output logic [1:0]       status,
  output logic [10:0]      wait_minutes,
  output logic [31:0]      wait_total,
  output logic [23:0]      served_total,
  output logic [23:0]      idle_events,
  output logic [6:0]       peak_length,
  output logic [6:0]       current_length
);

  mqwtm_pkg::item_t item;
  logic             item_valid;
  logic             pop;
  mqwtm_pkg::res_t  res;

  mqwtm_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .queue_id   (queue_id),
    .event_time (event_time),
    .item       (item),
    .item_valid (item_valid),
    .pop        (pop)
  );

  mqwtm_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .pop        (pop),
    .res        (res),
    .done       (done)
  );

  assign queue_sel      = res.queue_sel;
  assign status         = res.status;
  assign wait_minutes   = res.wait_minutes;
  assign wait_total     = res.wait_total;
  assign served_total   = res.served_total;
  assign idle_events    = res.idle_events;
  assign peak_length    = res.peak_length;
  assign current_length = res.current_length;

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes too close together");

  a_empty_exit: assert property (@(posedge clk) disable iff (rst)
    (done && status == mqwtm_pkg::ST_EMPTY) |-> (current_length == 7'd0 &&
      wait_minutes == 11'd0))
    else $error("exit on empty queue reported a length or wait");

  a_full_enter: assert property (@(posedge clk) disable iff (rst)
    (done && status == mqwtm_pkg::ST_FULL) |-> (current_length == 7'(QUEUE_DEPTH)))
    else $error("drop reported on a queue that is not full");

  a_wait_ok: assert property (@(posedge clk) disable iff (rst)
    (done && wait_minutes != 11'd0) |-> (status == mqwtm_pkg::ST_OK))
    else $error("nonzero wait with error status");

endmodule
`default_nettype wire
